>>> sv/assert_macros.svh
// Assertion macros shared by the frame parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define KFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define KFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/kfp_pkg.sv
// Package: types, constants and CRC helper of the key/value frame parser
`default_nettype none
package kfp_pkg;

  localparam int NUM_TYPES     = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_KEY_DEF   = 64;
  localparam int MAX_VALUE_DEF = 512;
  localparam int KEY_LEN_W     = 7;
  localparam int VAL_LEN_W     = 10;
  localparam int OUT_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_F = 3'd5;

  typedef logic [NUM_TYPES-1:0][7:0] kfp_codes_t;
  localparam kfp_codes_t TYPE_RESET = {8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // byte offsets within the frame header
  localparam int OFF_TYPE      = 0;
  localparam int OFF_TOTAL_END = 4;
  localparam int OFF_CSUM_END  = 6;
  localparam int CRC_START     = 7;
  localparam int OFF_KLEN_END  = 10;
  localparam int OFF_VLEN_BASE = 14;
  localparam int MIN_TOTAL     = 11;
  localparam int HDR_FIXED     = 15;

  localparam logic [1:0] PH_HEAD  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VLEN  = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]           item_kind;
    logic [7:0]           payload_byte;
    logic                 frame_status;
    logic [7:0]           message_type;
    logic [KEY_LEN_W-1:0] key_length;
    logic [VAL_LEN_W-1:0] value_length;
    logic [15:0]          stated_checksum;
    logic                 last_of_run;
  } kfp_item_t;

  // results of one parsed byte, in order
  typedef struct packed {
    logic [1:0] n;
    kfp_item_t  itm0;
    kfp_item_t  itm1;
  } kfp_push_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/kfp_in_if.sv
// Interface: input byte channel
`default_nettype none
interface kfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source(output valid, in_byte, end_of_buffer, input ready);
  modport sink(input valid, in_byte, end_of_buffer, output ready);
endinterface
`default_nettype wire

>>> sv/kfp_out_if.sv
// Interface: result item channel
`default_nettype none
interface kfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  payload_byte;
  logic        frame_status;
  logic [7:0]  message_type;
  logic [6:0]  key_length;
  logic [9:0]  value_length;
  logic [15:0] stated_checksum;
  logic        last_of_run;

  modport source(output valid, item_kind, payload_byte, frame_status, message_type,
                 key_length, value_length, stated_checksum, last_of_run, input ready);
  modport sink(input valid, item_kind, payload_byte, frame_status, message_type,
               key_length, value_length, stated_checksum, last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/kfp_cfg_regs.sv
// Type code configuration registers
`default_nettype none
module kfp_cfg_regs import kfp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  output kfp_codes_t                codes
);

  kfp_codes_t codes_r;
  kfp_codes_t codes_nxt;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TYPE_A: codes_nxt[0] = cfg_wdata;
        CFG_TYPE_B: codes_nxt[1] = cfg_wdata;
        CFG_TYPE_C: codes_nxt[2] = cfg_wdata;
        CFG_TYPE_D: codes_nxt[3] = cfg_wdata;
        CFG_TYPE_E: codes_nxt[4] = cfg_wdata;
        CFG_TYPE_F: codes_nxt[5] = cfg_wdata;
        default: codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= TYPE_RESET;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  assign codes = codes_r;

endmodule
`default_nettype wire

>>> sv/kfp_parse.sv
// Input register and per-byte frame parsing with CRC update
`default_nettype none
`include "assert_macros.svh"
module kfp_parse import kfp_pkg::*; #(
  parameter int MAX_KEY_BYTES   = MAX_KEY_DEF,
  parameter int MAX_VALUE_BYTES = MAX_VALUE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kfp_in_if.sink     in_ch,
  input  kfp_codes_t codes,
  input  wire logic  room,
  output kfp_push_t  push
);

  localparam int OFF_W = $clog2(MAX_KEY_BYTES + MAX_VALUE_BYTES + 16);
  localparam int KL_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int VL_W  = $clog2(MAX_VALUE_BYTES + 1);

  logic             inv_r;
  logic [7:0]       inb_r;
  logic             inlast_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [31:0]      klen_r, klen_nxt;
  logic [31:0]      vlen_r, vlen_nxt;
  logic [15:0]      csum_r, csum_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       type_r, type_nxt;
  logic             decided_r, decided_nxt;

  logic             fire;
  logic             type_hit;
  logic             fail, done, data_emit, stat_emit, stat_val;
  logic [1:0]       data_kind;
  logic [OFF_W-1:0] key_end, vlen_end, val_end;
  logic [31:0]      kl_sat, vl_sat;
  kfp_item_t        data_item, stat_item;

  assign fire        = inv_r && room;
  assign in_ch.ready = !inv_r || fire;

  assign key_end  = OFF_W'(OFF_KLEN_END) + OFF_W'(klen_r[KL_W-1:0]);
  assign vlen_end = OFF_W'(OFF_VLEN_BASE) + OFF_W'(klen_r[KL_W-1:0]);
  assign val_end  = vlen_end + OFF_W'(vlen_r[VL_W-1:0]);

  always_comb begin
    type_hit = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (codes[i] == inb_r) type_hit = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    total_nxt   = total_r;
    klen_nxt    = klen_r;
    vlen_nxt    = vlen_r;
    csum_nxt    = csum_r;
    crc_nxt     = crc_r;
    type_nxt    = type_r;
    decided_nxt = decided_r;
    fail        = 1'b0;
    done        = 1'b0;
    data_emit   = 1'b0;
    data_kind   = KIND_KEY;

    if (!decided_r) begin
      if (off_r >= OFF_W'(CRC_START)) crc_nxt = crc_byte(crc_r, inb_r);
      unique case (phase_r)
        PH_HEAD: begin
          if (off_r == OFF_W'(OFF_TYPE)) begin
            type_nxt = inb_r;
            fail     = !type_hit;
          end else if (off_r <= OFF_W'(OFF_TOTAL_END)) begin
            total_nxt = {total_r[23:0], inb_r};
            if (off_r == OFF_W'(OFF_TOTAL_END) && total_nxt < 32'(MIN_TOTAL)) fail = 1'b1;
          end else if (off_r <= OFF_W'(OFF_CSUM_END)) begin
            csum_nxt = {csum_r[7:0], inb_r};
          end else begin
            klen_nxt = {klen_r[23:0], inb_r};
            if (off_r == OFF_W'(OFF_KLEN_END)) begin
              if (klen_nxt > 32'(MAX_KEY_BYTES)) begin
                fail = 1'b1;
              end else begin
                phase_nxt = (klen_nxt != 32'd0) ? PH_KEY : PH_VLEN;
              end
            end
          end
        end
        PH_KEY: begin
          data_emit = 1'b1;
          data_kind = KIND_KEY;
          if (off_r == key_end) phase_nxt = PH_VLEN;
        end
        PH_VLEN: begin
          vlen_nxt = {vlen_r[23:0], inb_r};
          if (off_r == vlen_end) begin
            if (vlen_nxt > 32'(MAX_VALUE_BYTES) ||
                (32'(HDR_FIXED) + klen_r + vlen_nxt) != total_r) begin
              fail = 1'b1;
            end else if (vlen_nxt == 32'd0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          data_emit = 1'b1;
          data_kind = KIND_VALUE;
          if (off_r == val_end) done = 1'b1;
        end
        default: phase_nxt = phase_r;
      endcase
      if (!fail && !done && inlast_r) fail = 1'b1;
      off_nxt     = off_r + OFF_W'(1);
      decided_nxt = fail || done;
    end

    stat_emit = fail || done;
    stat_val  = fail ? ST_FAIL : ((crc_nxt == csum_nxt) ? ST_OK : ST_FAIL);
    kl_sat    = (klen_nxt > 32'(MAX_KEY_BYTES)) ? 32'(MAX_KEY_BYTES) : klen_nxt;
    vl_sat    = (vlen_nxt > 32'(MAX_VALUE_BYTES)) ? 32'(MAX_VALUE_BYTES) : vlen_nxt;

    data_item.item_kind       = data_kind;
    data_item.payload_byte    = inb_r;
    data_item.frame_status    = ST_OK;
    data_item.message_type    = type_nxt;
    data_item.key_length      = kl_sat[KEY_LEN_W-1:0];
    data_item.value_length    = vl_sat[VAL_LEN_W-1:0];
    data_item.stated_checksum = csum_nxt;
    data_item.last_of_run     = !stat_emit;

    stat_item              = data_item;
    stat_item.item_kind    = KIND_STATUS;
    stat_item.payload_byte = 8'h00;
    stat_item.frame_status = stat_val;
    stat_item.last_of_run  = 1'b1;

    // end of buffer returns everything but the type codes to reset
    if (inlast_r) begin
      phase_nxt   = PH_HEAD;
      off_nxt     = '0;
      total_nxt   = '0;
      klen_nxt    = '0;
      vlen_nxt    = '0;
      csum_nxt    = '0;
      crc_nxt     = CRC_INIT;
      type_nxt    = '0;
      decided_nxt = 1'b0;
    end
  end

  always_comb begin
    push.n    = fire ? (2'(data_emit) + 2'(stat_emit)) : 2'd0;
    push.itm0 = data_emit ? data_item : stat_item;
    push.itm1 = stat_item;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inb_r    <= in_ch.in_byte;
      inlast_r <= in_ch.end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r     <= 1'b0;
      phase_r   <= PH_HEAD;
      off_r     <= '0;
      total_r   <= '0;
      klen_r    <= '0;
      vlen_r    <= '0;
      csum_r    <= '0;
      crc_r     <= CRC_INIT;
      type_r    <= '0;
      decided_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        inv_r <= 1'b1;
      end else if (fire) begin
        inv_r <= 1'b0;
      end
      if (fire) begin
        phase_r   <= phase_nxt;
        off_r     <= off_nxt;
        total_r   <= total_nxt;
        klen_r    <= klen_nxt;
        vlen_r    <= vlen_nxt;
        csum_r    <= csum_nxt;
        crc_r     <= crc_nxt;
        type_r    <= type_nxt;
        decided_r <= decided_nxt;
      end
    end
  end

  `KFP_ASSERT_NEXT(a_status_decides, fire && stat_emit && !inlast_r, decided_r, "status without decision")
  `KFP_ASSERT(a_pair_order, push.n == 2'd2 |-> (push.itm1.item_kind == KIND_STATUS && !push.itm0.last_of_run), "bad result pair")

endmodule
`default_nettype wire

>>> sv/kfp_out_queue.sv
// Four-entry shifting result queue feeding the output channel
`default_nettype none
`include "assert_macros.svh"
module kfp_out_queue import kfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  kfp_push_t push,
  output logic      room,
  kfp_out_if.source out_ch
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int IDX_W = $clog2(OUT_DEPTH);

  kfp_item_t        q_r   [OUT_DEPTH];
  kfp_item_t        q_nxt [OUT_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] base1;
  logic             pop;

  assign out_ch.valid = cnt_r != '0;
  assign pop          = out_ch.valid && out_ch.ready;
  assign room         = cnt_r <= CNT_W'(OUT_DEPTH - 2);

  assign out_ch.item_kind       = q_r[0].item_kind;
  assign out_ch.payload_byte    = q_r[0].payload_byte;
  assign out_ch.frame_status    = q_r[0].frame_status;
  assign out_ch.message_type    = q_r[0].message_type;
  assign out_ch.key_length      = q_r[0].key_length;
  assign out_ch.value_length    = q_r[0].value_length;
  assign out_ch.stated_checksum = q_r[0].stated_checksum;
  assign out_ch.last_of_run     = q_r[0].last_of_run;

  always_comb begin
    base  = cnt_r - CNT_W'(pop);
    base1 = base + CNT_W'(1);
    for (int i = 0; i < OUT_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    if (push.n != 2'd0) q_nxt[base[IDX_W-1:0]] = push.itm0;
    if (push.n == 2'd2) q_nxt[base1[IDX_W-1:0]] = push.itm1;
    cnt_nxt = base + CNT_W'(push.n);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `KFP_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(OUT_DEPTH), "queue count above depth")
  `KFP_ASSERT(a_push_room, push.n != 2'd0 |-> cnt_r <= CNT_W'(OUT_DEPTH - 2), "push without room")

endmodule
`default_nettype wire

>>> sv/kv_frame_parser_crc16.sv
// Top level: length-prefixed key/value frame parser with CRC-16 check
//
//  channel  | dir | transfer when          | payload
//  in_ch    | in  | valid && ready         | in_byte, end_of_buffer
//  out_ch   | out | valid && ready         | item_kind .. last_of_run
//  cfg_*    | in  | cfg_we                 | cfg_index, cfg_wdata
//
// One byte per cycle while the output queue has room: a byte sits in the input
// register, is parsed combinationally, and its results enter a four-entry queue.
// A result passes the input register and then the queue on its way to out_ch.
// A byte giving a key/value item plus the status pushes two queue entries; input
// stalls while the queue holds more than two items.
// rst_n is synchronous; type codes return to 1..6, no clearing pass.
`default_nettype none
module kv_frame_parser_crc16 import kfp_pkg::*; #(
  parameter int MAX_KEY_BYTES   = MAX_KEY_DEF,
  parameter int MAX_VALUE_BYTES = MAX_VALUE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  kfp_in_if.sink                    in_ch,
  kfp_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  kfp_codes_t codes;
  kfp_push_t  push;
  logic       room;

  kfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .codes     (codes)
  );

  kfp_parse #(
    .MAX_KEY_BYTES   (MAX_KEY_BYTES),
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .codes (codes),
    .room  (room),
    .push  (push)
  );

  kfp_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> tb/sv/kv_frame_parser_crc16_tb.sv
// Testbench for kv_frame_parser_crc16: directed and random frames checked against a byte-level parser
`timescale 1ns / 100ps

module kv_frame_parser_crc16_tb;
  import kfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CODE_REGS [NUM_TYPES] = '{
    CFG_TYPE_A, CFG_TYPE_B, CFG_TYPE_C, CFG_TYPE_D, CFG_TYPE_E, CFG_TYPE_F
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  kfp_in_if  in_ch();
  kfp_out_if out_ch();

  kv_frame_parser_crc16 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // parser state tracked per buffer
  logic [1:0]  fr_phase;
  logic [31:0] fr_off;
  logic [31:0] fr_total;
  logic [31:0] fr_klen;
  logic [31:0] fr_vlen;
  logic [15:0] fr_csum;
  logic [15:0] fr_crc;
  logic [7:0]  fr_type;
  bit          fr_decided;
  kfp_codes_t  type_codes_now;

  kfp_item_t   items_due[$];
  logic [7:0]  frame_q[$];
  int unsigned error_count;
  int unsigned parsed_bytes;

  bit src_idles;
  bit sink_idles;
  int sink_hold_req;
  int sink_hold_left;
  int sink_stall_left;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic int idle_cycles();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 30));
  endfunction

  function automatic bit type_known(input logic [7:0] t);
    for (int i = 0; i < NUM_TYPES; i++)
      if (type_codes_now[i] == t) return 1'b1;
    return 1'b0;
  endfunction

  function automatic kfp_item_t frame_item(input logic [1:0] kind, input logic [7:0] data,
                                           input logic st);
    kfp_item_t it;
    it.item_kind       = kind;
    it.payload_byte    = data;
    it.frame_status    = st;
    it.message_type    = fr_type;
    it.key_length      = (fr_klen > MAX_KEY_DEF) ? KEY_LEN_W'(MAX_KEY_DEF)
                                                 : fr_klen[KEY_LEN_W-1:0];
    it.value_length    = (fr_vlen > MAX_VALUE_DEF) ? VAL_LEN_W'(MAX_VALUE_DEF)
                                                   : fr_vlen[VAL_LEN_W-1:0];
    it.stated_checksum = fr_csum;
    it.last_of_run     = 1'b0;
    return it;
  endfunction

  task automatic reset_frame_state();
    fr_phase   = PH_HEAD;
    fr_off     = '0;
    fr_total   = '0;
    fr_klen    = '0;
    fr_vlen    = '0;
    fr_csum    = '0;
    fr_crc     = CRC_INIT;
    fr_type    = '0;
    fr_decided = 1'b0;
  endtask

  // advance the parser by one accepted byte and queue the results it causes
  task automatic parse_frame_byte(input logic [7:0] b, input logic eob, output bit skipped);
    kfp_item_t res[2];
    int n;
    bit fail;
    bit done;
    logic [31:0] off;
    n = 0;
    fail = 1'b0;
    done = 1'b0;
    skipped = fr_decided;
    if (fr_decided) begin
      if (eob) reset_frame_state();
      return;
    end
    off = fr_off;
    if (off >= CRC_START) fr_crc = crc16_step(fr_crc, b);
    case (fr_phase)
      PH_HEAD: begin
        if (off == OFF_TYPE) begin
          fr_type = b;
          if (!type_known(b)) fail = 1'b1;
        end else if (off <= OFF_TOTAL_END) begin
          fr_total = {fr_total[23:0], b};
          if (off == OFF_TOTAL_END && fr_total < MIN_TOTAL) fail = 1'b1;
        end else if (off <= OFF_CSUM_END) begin
          fr_csum = {fr_csum[7:0], b};
        end else begin
          fr_klen = {fr_klen[23:0], b};
          if (off == OFF_KLEN_END) begin
            if (fr_klen > MAX_KEY_DEF) fail = 1'b1;
            else fr_phase = (fr_klen != 0) ? PH_KEY : PH_VLEN;
          end
        end
      end
      PH_KEY: begin
        res[n] = frame_item(KIND_KEY, b, ST_OK);
        n++;
        if (off == OFF_KLEN_END + fr_klen) fr_phase = PH_VLEN;
      end
      PH_VLEN: begin
        fr_vlen = {fr_vlen[23:0], b};
        if (off == OFF_VLEN_BASE + fr_klen) begin
          if (fr_vlen > MAX_VALUE_DEF || HDR_FIXED + fr_klen + fr_vlen != fr_total) fail = 1'b1;
          else if (fr_vlen == 0) done = 1'b1;
          else fr_phase = PH_VALUE;
        end
      end
      default: begin
        res[n] = frame_item(KIND_VALUE, b, ST_OK);
        n++;
        if (off == OFF_VLEN_BASE + fr_klen + fr_vlen) done = 1'b1;
      end
    endcase
    if (!fail && !done && eob) fail = 1'b1;
    fr_off = off + 1;
    if (fail || done) begin
      res[n] = frame_item(KIND_STATUS, 8'h00,
                          (fail || fr_crc != fr_csum) ? ST_FAIL : ST_OK);
      n++;
      fr_decided = 1'b1;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) items_due.push_back(res[i]);
    if (eob) reset_frame_state();
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    kfp_item_t got;
    kfp_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.item_kind, out_ch.payload_byte, out_ch.frame_status, out_ch.message_type,
             out_ch.key_length, out_ch.value_length, out_ch.stated_checksum,
             out_ch.last_of_run};
      if (items_due.size() == 0) begin
        report_mismatch("unexpected transfer, item_kind", 16'(got.item_kind), 16'h0);
      end else begin
        want = items_due.pop_front();
        if (got.item_kind !== want.item_kind)
          report_mismatch("item_kind", 16'(got.item_kind), 16'(want.item_kind));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        if (got.frame_status !== want.frame_status)
          report_mismatch("frame_status", 16'(got.frame_status), 16'(want.frame_status));
        if (got.message_type !== want.message_type)
          report_mismatch("message_type", 16'(got.message_type), 16'(want.message_type));
        if (got.key_length !== want.key_length)
          report_mismatch("key_length", 16'(got.key_length), 16'(want.key_length));
        if (got.value_length !== want.value_length)
          report_mismatch("value_length", 16'(got.value_length), 16'(want.value_length));
        if (got.stated_checksum !== want.stated_checksum)
          report_mismatch("stated_checksum", got.stated_checksum, want.stated_checksum);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
      end
    end
  end

  // result sink: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    sink_hold_left = 0;
    sink_stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        sink_hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (sink_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_stall_left > 0) begin
        out_ch.ready <= 1'b0;
        sink_stall_left--;
      end else if (sink_idles && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        sink_stall_left = idle_cycles() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    bit skipped;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!in_ch.ready);
    parse_frame_byte(b, eob, skipped);
    if (!skipped) parsed_bytes++;
    gap = (src_idles && $urandom_range(0, 99) < 45) ? idle_cycles() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_buffer();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic build_frame(input logic [7:0] mtype, input logic [31:0] total,
                             input logic [31:0] klen, input logic [31:0] vlen,
                             input bit csum_error);
    int nk;
    int nv;
    logic [15:0] crc;
    nk = (klen <= MAX_KEY_DEF) ? int'(klen) : 0;
    nv = (vlen <= MAX_VALUE_DEF) ? int'(vlen) : 0;
    frame_q.delete();
    frame_q.push_back(mtype);
    for (int i = 3; i >= 0; i--) frame_q.push_back(total[8*i +: 8]);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    for (int i = 3; i >= 0; i--) frame_q.push_back(klen[8*i +: 8]);
    for (int i = 0; i < nk; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 3; i >= 0; i--) frame_q.push_back(vlen[8*i +: 8]);
    for (int i = 0; i < nv; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    for (int i = CRC_START; i < frame_q.size(); i++) crc = crc16_step(crc, frame_q[i]);
    if (csum_error) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    frame_q[5] = crc[15:8];
    frame_q[6] = crc[7:0];
  endtask

  task automatic send_frame(input logic [7:0] mtype, input logic [31:0] klen,
                            input logic [31:0] vlen);
    build_frame(mtype, HDR_FIXED + klen + vlen, klen, vlen, 1'b0);
    send_buffer();
  endtask

  task automatic add_trailing(input int n);
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic cut_buffer(input int len);
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  // wait for every due result, then let ignored bytes drain through
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (items_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_type_codes(input kfp_codes_t codes);
    for (int i = 0; i < NUM_TYPES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CODE_REGS[i];
      cfg_wdata <= codes[i];
      @(posedge clk);
      type_codes_now[i] = codes[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_codes();
    src_idles = 1'b0;
    sink_idles = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) send_frame(type_codes_now[i], i, NUM_TYPES - i);
    settle_idle();
  endtask

  task automatic test_header_checks();
    src_idles = 1'b1;
    sink_idles = 1'b1;
    build_frame(8'h00, 32'd17, 32'd1, 32'd1, 1'b0);
    send_buffer();
    build_frame(8'hFF, 32'd17, 32'd1, 32'd1, 1'b0);
    send_buffer();
    build_frame(8'h01, 32'd10, 32'd0, 32'd0, 1'b0);
    send_buffer();
    build_frame(8'h02, 32'd0, 32'd0, 32'd0, 1'b0);
    send_buffer();
    build_frame(8'h03, 32'd80, 32'd65, 32'd0, 1'b0);
    send_buffer();
    build_frame(8'h04, 32'd15, 32'hFFFF_FFFF, 32'd0, 1'b0);
    add_trailing(3);
    send_buffer();
    build_frame(8'h05, 32'd528, 32'd0, 32'd513, 1'b0);
    send_buffer();
    build_frame(8'h06, 32'd15, 32'd2, 32'hFFFF_FFFF, 1'b0);
    send_buffer();
    build_frame(8'h01, 32'd21, 32'd2, 32'd3, 1'b0);
    send_buffer();
    build_frame(8'h02, 32'd11, 32'd0, 32'd0, 1'b0);
    send_buffer();
    build_frame(8'h03, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0);
    send_buffer();
    build_frame(8'h04, 32'd21, 32'd3, 32'd3, 1'b1);
    send_buffer();
    settle_idle();
  endtask

  task automatic test_short_buffers();
    int cuts[10] = '{1, 3, 5, 6, 9, 11, 13, 15, 17, 19};
    src_idles = 1'b1;
    sink_idles = 1'b1;
    foreach (cuts[i]) begin
      build_frame(type_codes_now[i % NUM_TYPES], 32'd20, 32'd2, 32'd3, 1'b0);
      cut_buffer(cuts[i]);
      send_buffer();
    end
    settle_idle();
  endtask

  task automatic test_trailing_bytes();
    src_idles = 1'b1;
    sink_idles = 1'b0;
    build_frame(8'h02, 32'd19, 32'd2, 32'd2, 1'b0);
    add_trailing(5);
    send_buffer();
    build_frame(8'h03, 32'd19, 32'd2, 32'd2, 1'b1);
    add_trailing(1);
    send_buffer();
    build_frame(8'h09, 32'd19, 32'd2, 32'd2, 1'b0);
    add_trailing(2);
    send_buffer();
    settle_idle();
  endtask

  task automatic test_empty_fields();
    src_idles = 1'b0;
    sink_idles = 1'b1;
    send_frame(8'h01, 32'd0, 32'd0);
    send_frame(8'h02, 32'd0, 32'd5);
    build_frame(8'h03, 32'd19, 32'd4, 32'd0, 1'b0);
    add_trailing(4);
    send_buffer();
    build_frame(8'h04, 32'd15, 32'd0, 32'd0, 1'b1);
    send_buffer();
    settle_idle();
  endtask

  task automatic test_size_limits();
    src_idles = 1'b1;
    sink_idles = 1'b1;
    send_frame(8'h05, MAX_KEY_DEF, MAX_VALUE_DEF);
    build_frame(8'h06, HDR_FIXED + MAX_KEY_DEF, MAX_KEY_DEF, 32'd0, 1'b1);
    send_buffer();
    send_frame(8'h01, MAX_KEY_DEF, 32'd1);
    settle_idle();
  endtask

  task automatic test_code_registers();
    kfp_codes_t codes;
    src_idles = 1'b1;
    sink_idles = 1'b1;
    codes[0] = 8'hFF;
    codes[1] = 8'h00;
    codes[2] = 8'h80;
    codes[3] = 8'h7F;
    codes[4] = 8'h55;
    codes[5] = 8'hAA;
    load_type_codes(codes);
    for (int i = 0; i < NUM_TYPES; i++) send_frame(codes[i], 32'd1, 32'd2);
    send_frame(8'h01, 32'd1, 32'd2);
    settle_idle();
    load_type_codes({NUM_TYPES{8'h00}});
    send_frame(8'h00, 32'd1, 32'd1);
    send_frame(8'hFF, 32'd1, 32'd1);
    settle_idle();
    load_type_codes(TYPE_RESET);
  endtask

  task automatic test_output_stall();
    src_idles = 1'b0;
    sink_idles = 1'b0;
    sink_hold_req = 150;
    send_frame(8'h03, 32'd24, 32'd40);
    settle_idle();
  endtask

  task automatic random_buffer();
    int r;
    int n;
    logic [7:0] t;
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [31:0] total;
    src_idles = ($urandom_range(0, 4) != 0);
    sink_idles = ($urandom_range(0, 4) != 0);
    t = ($urandom_range(0, 9) != 0) ? type_codes_now[$urandom_range(0, NUM_TYPES - 1)]
                                     : 8'($urandom_range(0, 255));
    r = int'($urandom_range(0, 99));
    klen = (r < 4) ? MAX_KEY_DEF : (r < 10) ? $urandom_range(9, 63) : $urandom_range(0, 6);
    r = int'($urandom_range(0, 99));
    vlen = (r < 1) ? $urandom_range(300, MAX_VALUE_DEF)
         : (r < 6) ? $urandom_range(17, 80) : $urandom_range(0, 12);
    total = HDR_FIXED + klen + vlen;
    r = int'($urandom_range(0, 99));
    if (r < 60) begin
      build_frame(t, total, klen, vlen, 1'b0);
    end else if (r < 68) begin
      build_frame(t, total, klen, vlen, 1'b1);
    end else if (r < 75) begin
      build_frame(t, total, klen, vlen, 1'b0);
      cut_buffer(int'($urandom_range(1, frame_q.size() - 1)));
    end else if (r < 81) begin
      build_frame(t, total, klen, vlen, 1'b0);
      add_trailing(int'($urandom_range(1, 6)));
    end else if (r < 85) begin
      build_frame(t, total ^ (32'h1 << $urandom_range(0, 31)), klen, vlen, 1'b0);
    end else if (r < 89) begin
      klen = $urandom_range(0, 1) ? $urandom_range(65, 300) : ($urandom | 32'h100);
      build_frame(t, total, klen, vlen, 1'b0);
    end else if (r < 93) begin
      vlen = $urandom_range(0, 1) ? $urandom_range(513, 2000) : ($urandom | 32'h400);
      build_frame(t, total, klen, vlen, 1'b0);
      add_trailing(int'($urandom_range(0, 4)));
    end else begin
      frame_q.delete();
      n = int'($urandom_range(1, 12));
      add_trailing(n);
    end
    send_buffer();
  endtask

  task automatic test_random_frames();
    kfp_codes_t codes;
    int goal;
    for (int ph = 0; ph < 3; ph++) begin
      settle_idle();
      for (int i = 0; i < NUM_TYPES; i++) codes[i] = 8'($urandom_range(0, 255));
      if (ph == 1) codes[NUM_TYPES - 1] = codes[0];
      if (ph == 2) begin
        codes[0] = 8'h00;
        codes[NUM_TYPES - 1] = 8'hFF;
      end
      load_type_codes(codes);
      goal = parsed_bytes + 170;
      while (parsed_bytes < goal) random_buffer();
    end
    settle_idle();
  endtask

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_buffer = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TYPE_A;
    cfg_wdata = 8'h00;
    src_idles = 1'b0;
    sink_idles = 1'b0;
    sink_hold_req = 0;
    error_count = 0;
    parsed_bytes = 0;
    type_codes_now = TYPE_RESET;
    reset_frame_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_codes();
    test_header_checks();
    test_short_buffers();
    test_trailing_bytes();
    test_empty_fields();
    test_size_limits();
    test_code_registers();
    test_output_stall();
    test_random_frames();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> kv_frame_parser_crc16.f
+incdir+sv
sv/kfp_pkg.sv
sv/kfp_in_if.sv
sv/kfp_out_if.sv
sv/kfp_cfg_regs.sv
sv/kfp_parse.sv
sv/kfp_out_queue.sv
sv/kv_frame_parser_crc16.sv
tb/sv/kv_frame_parser_crc16_tb.sv
